// ----- rtl/cau_pkg.sv -----
// Shared types, codes and helpers for the complex arithmetic unit.
package cau_pkg;

   localparam int DATA_WIDTH        = 16;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int PROD_WIDTH        = 2 * DATA_WIDTH;
   localparam int SUM_WIDTH         = PROD_WIDTH + 1;
   localparam int DIV_LAT           = DATA_WIDTH + 2;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DIVZERO = 2'd1,
      ST_SAT    = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]                   command;
      logic signed [DATA_WIDTH-1:0] a_re;
      logic signed [DATA_WIDTH-1:0] a_im;
      logic signed [DATA_WIDTH-1:0] b_re;
      logic signed [DATA_WIDTH-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_re;
      logic signed [DATA_WIDTH-1:0] res_im;
      logic [1:0]                   status;
   } rsp_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  clipped;
   } sat_type;

   function automatic sat_type saturate(input logic neg, input logic [DATA_WIDTH:0] mag);
      sat_type                 r;
      logic [DATA_WIDTH:0]     top;
      logic [DATA_WIDTH:0]     negv;
      top  = (DATA_WIDTH+1)'(1) << (DATA_WIDTH - 1);
      negv = (DATA_WIDTH+1)'(0) - mag;
      r.clipped = 1'b0;
      if (neg) begin
         if (mag > top) begin
            r.clipped = 1'b1;
            r.value   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         end else begin
            r.value = negv[DATA_WIDTH-1:0];
         end
      end else begin
         if (mag > top - (DATA_WIDTH+1)'(1)) begin
            r.clipped = 1'b1;
            r.value   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         end else begin
            r.value = mag[DATA_WIDTH-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/cau_div.sv -----
// Pipelined restoring divider: rounded quotient of num * 2^FRAC_BITS / den, one bit per stage.
module cau_div import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [PROD_WIDTH-1:0] num,
   input  logic [PROD_WIDTH-1:0] den,
   output logic [DATA_WIDTH:0]   quo
);

   localparam int NW = PROD_WIDTH;
   localparam int QW = DATA_WIDTH + 1;
   localparam int XW = NW + FRAC_BITS + 1 + QW;

   logic [NW-1:0] rem_ff [0:QW];
   logic [QW-1:0] lo_ff  [0:QW];
   logic [QW-1:0] q_ff   [0:QW];
   logic [NW-1:0] den_ff [0:QW];
   logic          ovf_ff [0:QW];

   logic [XW-1:0] num_x;
   logic [XW-1:0] den_x;
   logic [XW-1:0] r0_x;
   logic [QW:0]   q_inc;

   assign num_x = XW'(num) << (FRAC_BITS + 1);
   assign den_x = XW'(den) << QW;
   assign r0_x  = num_x >> QW;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= r0_x[NW-1:0];
         lo_ff[0]  <= num_x[QW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= (num_x >= den_x);
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [NW:0] t;
      logic [NW:0] d;
      logic        ge;
      assign t  = {rem_ff[k-1], lo_ff[k-1][QW-1]};
      assign d  = {1'b0, den_ff[k-1]};
      assign ge = (t >= d);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? NW'(t - d) : t[NW-1:0];
            lo_ff[k]  <= {lo_ff[k-1][QW-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign q_inc = {1'b0, q_ff[QW]} + (QW+1)'(1);
   assign quo   = ovf_ff[QW] ? {1'b1, {DATA_WIDTH{1'b0}}} : q_inc[QW:1];

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit top level: add, subtract, multiply and divide in signed fixed point.
// One transaction is accepted every cycle unless a result stalls. Each passes the request,
// product and operand registers, the restoring divider, which sets the depth and resolves
// one quotient bit per pipeline stage, and a result register. All commands share that path,
// so results leave in request order. A stalled result halts the whole pipeline.
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int W  = DATA_WIDTH;
   localparam int HS = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
   localparam logic [SUM_WIDTH:0] HALF =
      (FRAC_BITS > 0) ? ((SUM_WIDTH+1)'(1) << HS) : '0;
   localparam logic [W:0] MAG_TOP = (W+1)'(1) << W;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        divzero;
      logic        neg_re;
      logic        neg_im;
      logic [W:0]  pre_re;
      logic [W:0]  pre_im;
   } side_type;

   logic en;

   logic    v1_ff;
   req_type s1_ff;

   logic                          v2_ff;
   logic [1:0]                    cmd2_ff;
   logic signed [PROD_WIDTH-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [W:0]             add_re_ff, add_im_ff;
   logic signed [PROD_WIDTH-1:0]  p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_bb_in, p_cc_in;
   logic signed [W:0]             add_re_in, add_im_in;

   logic                  v3_ff;
   side_type              side3_ff, side3_in;
   logic [PROD_WIDTH-1:0] num_re_ff, num_im_ff, den_ff;
   logic [PROD_WIDTH-1:0] num_re_in, num_im_in, den_in;

   logic signed [SUM_WIDTH-1:0] re_s, im_s;
   logic [SUM_WIDTH-1:0]        re_m, im_m, den_s;
   logic [SUM_WIDTH:0]          rnd_re, rnd_im;
   logic [W:0]                  add_re_m, add_im_m;

   logic     vp_ff   [0:DIV_LAT-1];
   side_type side_ff [0:DIV_LAT-1];

   logic [W:0] quo_re, quo_im;
   logic [W:0] fin_re, fin_im;
   sat_type    sat_re, sat_im;
   rsp_type    rsp_in, rsp_ff;
   logic       rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= req_payload;
      end
   end

   assign p_rr_in = s1_ff.a_re * s1_ff.b_re;
   assign p_ii_in = s1_ff.a_im * s1_ff.b_im;
   assign p_ri_in = s1_ff.a_re * s1_ff.b_im;
   assign p_ir_in = s1_ff.a_im * s1_ff.b_re;
   assign p_bb_in = s1_ff.b_re * s1_ff.b_re;
   assign p_cc_in = s1_ff.b_im * s1_ff.b_im;
   assign add_re_in = (s1_ff.command == CMD_SUB) ?
      (W+1)'(s1_ff.a_re) - (W+1)'(s1_ff.b_re) : (W+1)'(s1_ff.a_re) + (W+1)'(s1_ff.b_re);
   assign add_im_in = (s1_ff.command == CMD_SUB) ?
      (W+1)'(s1_ff.a_im) - (W+1)'(s1_ff.b_im) : (W+1)'(s1_ff.a_im) + (W+1)'(s1_ff.b_im);

   always_ff @(posedge clock) begin
      if (en) begin
         cmd2_ff   <= s1_ff.command;
         p_rr_ff   <= p_rr_in;
         p_ii_ff   <= p_ii_in;
         p_ri_ff   <= p_ri_in;
         p_ir_ff   <= p_ir_in;
         p_bb_ff   <= p_bb_in;
         p_cc_ff   <= p_cc_in;
         add_re_ff <= add_re_in;
         add_im_ff <= add_im_in;
      end
   end

   always_comb begin
      if (cmd2_ff == CMD_MUL) begin
         re_s = SUM_WIDTH'(p_rr_ff) - SUM_WIDTH'(p_ii_ff);
         im_s = SUM_WIDTH'(p_ri_ff) + SUM_WIDTH'(p_ir_ff);
      end else begin
         re_s = SUM_WIDTH'(p_rr_ff) + SUM_WIDTH'(p_ii_ff);
         im_s = SUM_WIDTH'(p_ir_ff) - SUM_WIDTH'(p_ri_ff);
      end
      re_m     = re_s[SUM_WIDTH-1] ? SUM_WIDTH'(-re_s) : SUM_WIDTH'(re_s);
      im_m     = im_s[SUM_WIDTH-1] ? SUM_WIDTH'(-im_s) : SUM_WIDTH'(im_s);
      den_s    = SUM_WIDTH'(p_bb_ff) + SUM_WIDTH'(p_cc_ff);
      rnd_re   = ({1'b0, re_m} + HALF) >> FRAC_BITS;
      rnd_im   = ({1'b0, im_m} + HALF) >> FRAC_BITS;
      add_re_m = add_re_ff[W] ? (W+1)'(-add_re_ff) : (W+1)'(add_re_ff);
      add_im_m = add_im_ff[W] ? (W+1)'(-add_im_ff) : (W+1)'(add_im_ff);

      side3_in.cmd     = cmd2_ff;
      side3_in.divzero = (den_s == '0);
      if (cmd2_ff == CMD_ADD || cmd2_ff == CMD_SUB) begin
         side3_in.neg_re = add_re_ff[W];
         side3_in.neg_im = add_im_ff[W];
         side3_in.pre_re = add_re_m;
         side3_in.pre_im = add_im_m;
      end else begin
         side3_in.neg_re = re_s[SUM_WIDTH-1];
         side3_in.neg_im = im_s[SUM_WIDTH-1];
         side3_in.pre_re = (rnd_re > (SUM_WIDTH+1)'(MAG_TOP)) ? MAG_TOP : rnd_re[W:0];
         side3_in.pre_im = (rnd_im > (SUM_WIDTH+1)'(MAG_TOP)) ? MAG_TOP : rnd_im[W:0];
      end
      num_re_in = re_m[PROD_WIDTH-1:0];
      num_im_in = im_m[PROD_WIDTH-1:0];
      den_in    = den_s[PROD_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff  <= side3_in;
         num_re_ff <= num_re_in;
         num_im_ff <= num_im_in;
         den_ff    <= den_in;
      end
   end

   cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
      .clock (clock),
      .en    (en),
      .num   (num_re_ff),
      .den   (den_ff),
      .quo   (quo_re)
   );

   cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
      .clock (clock),
      .en    (en),
      .num   (num_im_ff),
      .den   (den_ff),
      .quo   (quo_im)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            vp_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vp_ff[0] <= v3_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            vp_ff[i] <= vp_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side3_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_comb begin
      fin_re = (side_ff[DIV_LAT-1].cmd == CMD_DIV) ? quo_re : side_ff[DIV_LAT-1].pre_re;
      fin_im = (side_ff[DIV_LAT-1].cmd == CMD_DIV) ? quo_im : side_ff[DIV_LAT-1].pre_im;
      sat_re = saturate(side_ff[DIV_LAT-1].neg_re, fin_re);
      sat_im = saturate(side_ff[DIV_LAT-1].neg_im, fin_im);
      if (side_ff[DIV_LAT-1].cmd == CMD_DIV && side_ff[DIV_LAT-1].divzero) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.status = ST_DIVZERO;
      end else begin
         rsp_in.res_re = sat_re.value;
         rsp_in.res_im = sat_im.value;
         rsp_in.status = (sat_re.clipped || sat_im.clipped) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vp_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_ready_rule : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output stall");

   a_divzero_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_DIVZERO) |->
      (rsp_payload.res_re == '0 && rsp_payload.res_im == '0))
      else $error("divide-by-zero transaction carries a nonzero result");

   a_sat_extreme : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_SAT) |->
      (rsp_payload.res_re == {1'b1, {(W-1){1'b0}}} ||
       rsp_payload.res_re == {1'b0, {(W-1){1'b1}}} ||
       rsp_payload.res_im == {1'b1, {(W-1){1'b0}}} ||
       rsp_payload.res_im == {1'b0, {(W-1){1'b1}}}))
      else $error("saturated transaction has no part at a range limit");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == ST_OK || rsp_payload.status == ST_DIVZERO ||
                     rsp_payload.status == ST_SAT))
      else $error("undefined status code on result");

endmodule

// ----- sim/complex_arithmetic_unit_test.sv -----
// Testbench for the complex arithmetic unit: random and directed operands checked against a fixed-point predictor.
`timescale 1ns / 100ps
module complex_arithmetic_unit_test;
   import cau_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 20000;

   class result_scoreboard;
      rsp_type pending_results[$];
      int      mismatch_count;

      function automatic logic [63:0] clip(input logic neg, input logic [63:0] mag,
                                           inout logic clipped);
         logic [63:0] top;
         top = 64'd1 << (DATA_WIDTH - 1);
         if (neg) begin
            if (mag > top) begin
               clipped = 1'b1;
               mag = top;
            end
            return 64'd0 - mag;
         end
         if (mag > top - 64'd1) begin
            clipped = 1'b1;
            mag = top - 64'd1;
         end
         return mag;
      endfunction

      function automatic logic [63:0] div_round(input logic [63:0] num, input logic [63:0] den);
         logic [63:0] q;
         logic [63:0] r;
         logic        hi;
         q = num / den;
         r = num % den;
         if (q > (64'd1 << 33)) q = 64'd1 << 33;
         for (int i = 0; i < FRAC + 1; i++) begin
            hi = r[63];
            r = r << 1;
            q = q << 1;
            if (hi || r >= den) begin
               r = r - den;
               q[0] = 1'b1;
            end
         end
         return (q + 64'd1) >> 1;
      endfunction

      function automatic rsp_type compute_result(input req_type req);
         longint      ar, ai, br, bi, sr, si, den, nre_v, nim_v;
         logic        clipped;
         logic [63:0] half, mre, mim;
         rsp_type     r;
         ar = req.a_re;
         ai = req.a_im;
         br = req.b_re;
         bi = req.b_im;
         clipped = 1'b0;
         half = (FRAC > 0) ? (64'd1 << (FRAC - 1)) : 64'd0;
         r.status = ST_OK;
         r.res_re = '0;
         r.res_im = '0;
         case (cmd_type'(req.command))
            CMD_ADD, CMD_SUB: begin
               sr = (req.command == CMD_ADD) ? ar + br : ar - br;
               si = (req.command == CMD_ADD) ? ai + bi : ai - bi;
               r.res_re = DATA_WIDTH'(clip(sr < 0, sr < 0 ? -sr : sr, clipped));
               r.res_im = DATA_WIDTH'(clip(si < 0, si < 0 ? -si : si, clipped));
            end
            CMD_MUL: begin
               nre_v = ar * br - ai * bi;
               nim_v = ar * bi + ai * br;
               mre = nre_v < 0 ? -nre_v : nre_v;
               mim = nim_v < 0 ? -nim_v : nim_v;
               r.res_re = DATA_WIDTH'(clip(nre_v < 0, (mre + half) >> FRAC, clipped));
               r.res_im = DATA_WIDTH'(clip(nim_v < 0, (mim + half) >> FRAC, clipped));
            end
            default: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  r.status = ST_DIVZERO;
               end else begin
                  nre_v = ar * br + ai * bi;
                  nim_v = ai * br - ar * bi;
                  mre = nre_v < 0 ? -nre_v : nre_v;
                  mim = nim_v < 0 ? -nim_v : nim_v;
                  r.res_re = DATA_WIDTH'(clip(nre_v < 0, div_round(mre, den), clipped));
                  r.res_im = DATA_WIDTH'(clip(nim_v < 0, div_round(mim, den), clipped));
               end
            end
         endcase
         if (clipped) r.status = ST_SAT;
         return r;
      endfunction

      function void note_request(input req_type req);
         pending_results = {pending_results, compute_result(req)};
      endfunction

      function void check_result(input rsp_type actual);
         rsp_type wanted;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result re=%0d im=%0d st=%0d",
                        actual.res_re, actual.res_im, actual.status);
            return;
         end
         wanted = pending_results.pop_front();
         if (wanted !== actual) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("expected re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                        wanted.res_re, wanted.res_im, wanted.status,
                        actual.res_re, actual.res_im, actual.status);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   result_scoreboard board = new();
   int  send_idle_pct = 37;
   int  recv_idle_pct = 86;
   int  hold_off_cycles = 0;
   int  quiet_cycles = 0;
   bit  stimulus_done = 1'b0;

   complex_arithmetic_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_payload);
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic [15:0] edge_value();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] small_value();
      return 16'($signed($urandom_range(2047)) - 1024);
   endfunction

   task automatic send_request(input cmd_type command, input logic [15:0] a_re,
                               input logic [15:0] a_im, input logic [15:0] b_re,
                               input logic [15:0] b_im);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= {command, a_re, a_im, b_re, b_im};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      cmd_type command;
      for (int i = 0; i < count; i++) begin
         command = cmd_type'($urandom_range(3));
         case ($urandom_range(9))
            0, 1: send_request(command, edge_value(), edge_value(), edge_value(), edge_value());
            2: send_request(command, 16'($urandom), 16'($urandom), 16'h0000, 16'h0000);
            3, 4: send_request(command, 16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom));
            default: send_request(command, small_value(), small_value(), small_value(),
                                  small_value());
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int c = 0; c < 4; c++) begin
         send_request(cmd_type'(c), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
         send_request(cmd_type'(c), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
         send_request(cmd_type'(c), 16'h0100, 16'hff00, 16'h0080, 16'h0000);
         send_request(cmd_type'(c), 16'h1234, 16'hedcb, 16'h0000, 16'h0000);
         send_request(cmd_type'(c), 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
      end
      send_request(CMD_DIV, 16'h0001, 16'h0000, 16'h0003, 16'h0000);
      send_request(CMD_MUL, 16'h0001, 16'h0000, 16'h0080, 16'h0000);
      send_random(550);
      hold_off_cycles = 300;
      send_idle_pct = 0;
      send_random(60);
      send_idle_pct = 86;
      recv_idle_pct = 37;
      send_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(570);
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DIV_LAT + 20) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ----- complex_arithmetic_unit.f -----
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_test.sv
